@@ hw/rtl/pvvs_pkg.sv @@
// ----------------------------------------------------------------------------
// pvvs_pkg
// shared types and constants of the point vortex velocity sum unit
// ----------------------------------------------------------------------------
package pvvs_pkg;

  // table size and derived widths
  localparam int MaxEntries = 64;
  localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW       = $clog2(MaxEntries + 1);

  // one table entry: x, y, weight
  localparam int EntryW     = 64;

  // divider widths: numerator magnitude |d|*|w|*16, divisor r2
  localparam int NumW       = 51;
  localparam int DenW       = 33;
  localparam int BitCntW    = $clog2(NumW + 1);

  // command codes
  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // register indexes (paddr bit 2)
  localparam logic RegActiveCount = 1'b0;
  localparam logic RegCircGain    = 1'b1;

  localparam logic [6:0]         ActiveCountRst = 7'd0;
  localparam logic signed [15:0] CircGainRst    = 16'sd4096;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         entry_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] strength;
    logic signed [15:0] spin;
  } pvvs_in_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               saturated;
  } pvvs_out_t;

endpackage

@@ hw/rtl/pvvs_ram.sv @@
// ----------------------------------------------------------------------------
// pvvs_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pvvs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/point_vortex_velocity_sum_unit.sv @@
// ----------------------------------------------------------------------------
// point_vortex_velocity_sum_unit
// biot-savart velocity sum over a table of point vortices
// ----------------------------------------------------------------------------
// A load item (cmd 0) writes one table entry (x, y, strength*spin) in the
// cycle it is accepted and leaves busy low, so loads can go back to back. A
// query item (cmd 1) walks entries 0 .. min(active_count, 64)-1 out of one
// 64-bit wide table ram. Each entry goes through ram read, difference,
// multiply, setup, a bit-serial restoring divider over the 51-bit
// numerators (the x and y quotients run side by side on a shared r2), and
// accumulate; an entry at zero distance skips the divider. After the walk
// the sums are scaled by circulation_gain and saturated; the divider loop
// dominates the time a query takes. The result is shown for exactly one
// cycle on result_o with result_valid_o high; the receiver cannot stall
// it. Configuration is through the apb port, active count at byte address
// 0 and circulation gain at byte address 4.
// ----------------------------------------------------------------------------
module point_vortex_velocity_sum_unit
  import pvvs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // command channel
  input  logic             start,
  output logic             busy,
  input  pvvs_in_t         item_i,
  // result channel
  output logic             result_valid_o,
  output pvvs_out_t        result_o,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [3:0] {
    StIdle, StFetch, StDiff, StMul, StSetup, StDiv, StAcc, StFinMul, StFinOut
  } state_e;

  state_e state_q;

  // configuration registers
  logic [6:0]         active_count_q;
  logic signed [15:0] circ_gain_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= ActiveCountRst;
      circ_gain_q    <= CircGainRst;
    end else if (cfg_we) begin
      case (paddr[2])
        RegActiveCount: active_count_q <= pwdata[6:0];
        RegCircGain:    circ_gain_q    <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegActiveCount: prdata = {25'd0, active_count_q};
      RegCircGain:    prdata = {{16{circ_gain_q[15]}}, circ_gain_q};
      default:        prdata = '0;
    endcase
  end

  // accept and table write
  logic accept;
  logic ram_we;
  logic signed [31:0] load_weight;
  logic [EntryW-1:0]  ram_wdata;
  logic [EntryW-1:0]  ram_rdata;

  assign busy        = (state_q != StIdle);
  assign accept      = start && !busy;
  assign ram_we      = accept && (item_i.cmd == CmdLoad)
                       && (32'(item_i.entry_index) < MaxEntries);
  assign load_weight = item_i.strength * item_i.spin;
  assign ram_wdata   = {item_i.coord_x, item_i.coord_y, load_weight};

  // walk control
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_lim;

  assign count_lim = (32'(active_count_q) > MaxEntries) ? CntW'(MaxEntries)
                                                         : CntW'(active_count_q);

  pvvs_ram #(
    .Width (EntryW),
    .Depth (MaxEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (item_i.entry_index[IdxW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // query point, held over the walk
  logic signed [15:0] qx_q, qy_q;

  // difference stage
  logic signed [15:0] ent_x, ent_y;
  logic signed [31:0] ent_w;
  logic signed [16:0] dx, dy;
  logic signed [31:0] neg_w;
  logic [15:0] adx_q, ady_q;
  logic [30:0] aw_q;
  logic        negx_q, negy_q;

  assign ent_x = ram_rdata[63:48];
  assign ent_y = ram_rdata[47:32];
  assign ent_w = ram_rdata[31:0];
  assign dx    = {qx_q[15], qx_q} - {ent_x[15], ent_x};
  assign dy    = {qy_q[15], qy_q} - {ent_y[15], ent_y};
  assign neg_w = -ent_w;

  // multiply stage
  logic [31:0] dx2_q, dy2_q;
  logic [46:0] px_q, py_q;

  // divider: both quotients share r2; the numerator register fills with
  // quotient bits as it shifts out
  logic [DenW-1:0]    r2_q;
  logic [DenW:0]      r2_sum;
  logic [NumW-1:0]    numx_q, numy_q;
  logic [DenW-1:0]    remx_q, remy_q;
  logic [DenW:0]      remx_sh, remy_sh;
  logic               gex, gey;
  logic [BitCntW-1:0] bit_cnt_q;

  assign r2_sum  = {1'b0, dx2_q} + {1'b0, dy2_q};
  assign remx_sh = {remx_q, numx_q[NumW-1]};
  assign remy_sh = {remy_q, numy_q[NumW-1]};
  assign gex     = remx_sh >= {1'b0, r2_q};
  assign gey     = remy_sh >= {1'b0, r2_q};

  // accumulators and finish
  logic signed [63:0] sumx_q, sumy_q;
  logic signed [63:0] qx_ext, qy_ext;
  logic signed [61:0] prodx_q, prody_q;

  assign qx_ext = {{(64-NumW){1'b0}}, numx_q};
  assign qy_ext = {{(64-NumW){1'b0}}, numy_q};

  function automatic logic signed [45:0] clamp44(input logic signed [63:0] s);
    logic signed [63:0] lim;
    lim = 64'sd1 <<< 44;
    if (s > lim) begin
      clamp44 = 46'(lim);
    end else if (s < -lim) begin
      clamp44 = 46'(-lim);
    end else begin
      clamp44 = 46'(s);
    end
  endfunction

  function automatic logic [32:0] sat32(input logic signed [61:0] p);
    logic signed [61:0] v;
    v = p >>> 12;
    if (v > 62'sd2147483647) begin
      sat32 = {1'b1, 32'h7fffffff};
    end else if (v < -62'sd2147483648) begin
      sat32 = {1'b1, 32'h80000000};
    end else begin
      sat32 = {1'b0, v[31:0]};
    end
  endfunction

  logic [32:0] satx, saty;
  assign satx = sat32(prodx_q);
  assign saty = sat32(prody_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      result_valid_o <= 1'b0;
      idx_q          <= '0;
      count_q        <= '0;
      bit_cnt_q      <= '0;
    end else begin
      result_valid_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept && (item_i.cmd == CmdQuery)) begin
            qx_q    <= item_i.coord_x;
            qy_q    <= item_i.coord_y;
            sumx_q  <= '0;
            sumy_q  <= '0;
            idx_q   <= '0;
            count_q <= count_lim;
            // empty table goes straight to scaling
            state_q <= (count_lim == '0) ? StFinMul : StFetch;
          end
        end
        StFetch: begin
          state_q <= StDiff;
        end
        StDiff: begin
          adx_q   <= dx[16] ? 16'(-dx) : 16'(dx);
          ady_q   <= dy[16] ? 16'(-dy) : 16'(dy);
          aw_q    <= ent_w[31] ? neg_w[30:0] : ent_w[30:0];
          // x term has the sign of -dy*w, y term of dx*w
          negx_q  <= !dy[16] ^ ent_w[31];
          negy_q  <= dx[16] ^ ent_w[31];
          state_q <= StMul;
        end
        StMul: begin
          dx2_q   <= adx_q * adx_q;
          dy2_q   <= ady_q * ady_q;
          px_q    <= ady_q * aw_q;
          py_q    <= adx_q * aw_q;
          state_q <= StSetup;
        end
        StSetup: begin
          r2_q      <= r2_sum[DenW-1:0];
          numx_q    <= {px_q, 4'b0000};
          numy_q    <= {py_q, 4'b0000};
          remx_q    <= '0;
          remy_q    <= '0;
          bit_cnt_q <= '0;
          // zero distance: both numerators are zero, entry adds nothing
          state_q   <= (r2_sum == '0) ? StAcc : StDiv;
        end
        StDiv: begin
          remx_q    <= gex ? DenW'(remx_sh - {1'b0, r2_q}) : DenW'(remx_sh);
          remy_q    <= gey ? DenW'(remy_sh - {1'b0, r2_q}) : DenW'(remy_sh);
          numx_q    <= {numx_q[NumW-2:0], gex};
          numy_q    <= {numy_q[NumW-2:0], gey};
          bit_cnt_q <= bit_cnt_q + 1'b1;
          if (bit_cnt_q == BitCntW'(NumW - 1)) begin
            state_q <= StAcc;
          end
        end
        StAcc: begin
          sumx_q <= sumx_q + (negx_q ? -qx_ext : qx_ext);
          sumy_q <= sumy_q + (negy_q ? -qy_ext : qy_ext);
          idx_q  <= idx_q + 1'b1;
          state_q <= (idx_q + 1'b1 == count_q) ? StFinMul : StFetch;
        end
        StFinMul: begin
          prodx_q <= clamp44(sumx_q) * circ_gain_q;
          prody_q <= clamp44(sumy_q) * circ_gain_q;
          state_q <= StFinOut;
        end
        StFinOut: begin
          result_o.vel_x     <= satx[31:0];
          result_o.vel_y     <= saty[31:0];
          result_o.saturated <= satx[32] | saty[32];
          result_valid_o     <= 1'b1;
          state_q            <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // a result strobe lasts one cycle and leaves the block idle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (state_q == StIdle) ##1 !result_valid_o)
    else $error("result strobe longer than one cycle");

  // a load never makes the block busy
  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.cmd == CmdLoad) |=> !busy)
    else $error("load raised busy");

  // the table is written only while idle, so the walk never sees a write
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == StIdle))
    else $error("table write during a query");

  // the walk index stays inside the active range
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFetch) |-> (idx_q < count_q))
    else $error("walk index past active count");

endmodule
